// ----- rtl/mrtu_pkg.sv -----
// shared types, constants and functions of the modbus rtu frame checker
`default_nettype none
package mrtu_pkg;

   // configuration register indexes
   localparam logic [1:0] REG_PARSE_ROLE = 2'd0;
   localparam logic [1:0] REG_READ_FC    = 2'd1;
   localparam logic [1:0] REG_WRITE_FC   = 2'd2;
   localparam logic [1:0] REG_CRC_INIT   = 2'd3;

   // reset values of the registers
   localparam logic        ROLE_RESET     = 1'b0;
   localparam logic [7:0]  READ_FC_RESET  = 8'd3;
   localparam logic [7:0]  WRITE_FC_RESET = 8'd16;
   localparam logic [15:0] CRC_INIT_RESET = 16'hFFFF;

   // reflected crc-16 polynomial
   localparam logic [15:0] CRC_POLY = 16'hA001;

   // fixed frame lengths and data field starts
   localparam logic [8:0] FIXED_LEN      = 9'd8;
   localparam logic [8:0] COUNT_FIRST_OH = 9'd5;
   localparam logic [8:0] ACD_OH         = 9'd9;
   localparam logic [8:0] COUNT_FIRST_DS = 9'd3;
   localparam logic [8:0] ACD_DS         = 9'd7;
   localparam logic [8:0] POS_MAX        = 9'd511;

   // result kinds
   localparam logic KIND_PAYLOAD = 1'b0;
   localparam logic KIND_REPORT  = 1'b1;

   // input commands
   localparam logic CMD_BYTE      = 1'b0;
   localparam logic CMD_FRAME_END = 1'b1;

   typedef enum logic [1:0] {
      LAYOUT_NONE,
      LAYOUT_COUNT_FIRST,
      LAYOUT_FIXED,
      LAYOUT_ADDR_COUNT_DATA
   } layout_type;

   typedef enum logic [1:0] {
      STATUS_OK,
      STATUS_SHORT,
      STATUS_CRC,
      STATUS_UNKNOWN
   } status_type;

   typedef struct packed {
      logic        parse_role;
      logic [7:0]  read_fc;
      logic [7:0]  write_fc;
      logic [15:0] crc_init;
   } cfg_type;

   typedef struct packed {
      logic        result_kind;
      logic [7:0]  payload_value;
      logic [7:0]  payload_index;
      logic [7:0]  device_id;
      logic [7:0]  function_code;
      logic [15:0] start_address;
      logic [15:0] register_count;
      logic [7:0]  data_byte_count;
      status_type  frame_status;
      logic [8:0]  frame_length;
      logic        overlong;
   } res_type;

   // frame layout picked by the function code and the role
   function automatic layout_type layout_of(input logic [7:0] fc, input cfg_type cfg);
      layout_type k;
      k = LAYOUT_NONE;
      if (fc == cfg.read_fc) begin
         k = cfg.parse_role ? LAYOUT_FIXED : LAYOUT_COUNT_FIRST;
      end else if (fc == cfg.write_fc) begin
         k = cfg.parse_role ? LAYOUT_ADDR_COUNT_DATA : LAYOUT_FIXED;
      end
      return k;
   endfunction

   // one byte through the reflected crc-16, one bit per step
   function automatic logic [15:0] crc_update(input logic [15:0] crc, input logic [7:0] b);
      logic [15:0] c;
      c = crc ^ {8'h00, b};
      for (int i = 0; i < 8; i++) begin
         c = c[0] ? ((c >> 1) ^ CRC_POLY) : (c >> 1);
      end
      return c;
   endfunction

endpackage
`default_nettype wire

// ----- rtl/mrtu_cfg.sv -----
// configuration registers of the frame checker
`default_nettype none
module mrtu_cfg
   import mrtu_pkg::*;
(
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        csr_we,
   input  wire logic [1:0]  csr_addr,
   input  wire logic [15:0] csr_wdata,
   output cfg_type          cfg
);

   cfg_type cfg_ff;
   cfg_type cfg_in;

   // register write decode
   always_comb begin
      cfg_in = cfg_ff;
      if (csr_we) begin
         case (csr_addr)
            REG_PARSE_ROLE: cfg_in.parse_role = csr_wdata[0];
            REG_READ_FC:    cfg_in.read_fc    = csr_wdata[7:0];
            REG_WRITE_FC:   cfg_in.write_fc   = csr_wdata[7:0];
            REG_CRC_INIT:   cfg_in.crc_init   = csr_wdata;
            default:        cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.parse_role <= ROLE_RESET;
         cfg_ff.read_fc    <= READ_FC_RESET;
         cfg_ff.write_fc   <= WRITE_FC_RESET;
         cfg_ff.crc_init   <= CRC_INIT_RESET;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   assign cfg = cfg_ff;

endmodule
`default_nettype wire

// ----- rtl/mrtu_parser.sv -----
// frame state, running crc and result build for one transfer
`default_nettype none
module mrtu_parser
   import mrtu_pkg::*;
(
   input  wire logic       clock,
   input  wire logic       reset,
   input  cfg_type         cfg,
   input  wire logic       xfer,
   input  wire logic       cmd,
   input  wire logic [7:0] rx_byte,
   output logic            res_valid,
   output res_type         res
);

   logic [8:0]  pos_ff,  pos_in;
   logic [15:0] crc_ff,  crc_in;
   logic [7:0]  dev_ff,  dev_in;
   logic [7:0]  fc_ff,   fc_in;
   logic [15:0] addr_ff, addr_in;
   logic [15:0] cnt_ff,  cnt_in;
   logic [7:0]  bc_ff,   bc_in;
   logic [7:0]  tlo_ff,  tlo_in;
   logic [7:0]  thi_ff,  thi_in;
   logic [8:0]  exp_ff,  exp_in;

   layout_type  k_end;
   layout_type  k_byte;
   logic [7:0]  fc_now;
   logic [9:0]  pos_plus2;
   logic [8:0]  start;
   logic [8:0]  data_end;
   logic        in_frame;
   status_type  status;
   logic [8:0]  len;
   logic        over;

   assign in_frame  = (exp_ff == 9'd0) || (pos_ff < exp_ff);
   assign pos_plus2 = {1'b0, pos_ff} + 10'd2;
   assign fc_now    = (pos_ff == 9'd1) ? rx_byte : fc_ff;
   assign k_end     = layout_of(fc_ff, cfg);
   assign k_byte    = layout_of(fc_now, cfg);
   assign data_end  = start + {1'b0, bc_ff};

   // frame end status
   always_comb begin
      len = 9'd0;
      if (pos_ff == 9'd0) begin
         status = STATUS_UNKNOWN;
      end else if (pos_ff == 9'd1) begin
         status = STATUS_SHORT;
      end else if (k_end == LAYOUT_NONE) begin
         status = STATUS_UNKNOWN;
      end else if (in_frame) begin
         status = STATUS_SHORT;
      end else if ({thi_ff, tlo_ff} != crc_ff) begin
         status = STATUS_CRC;
      end else begin
         status = STATUS_OK;
         len    = exp_ff;
      end
      over = (exp_ff != 9'd0) && (pos_ff > exp_ff);
   end

   // data field start for the current layout
   always_comb begin
      start = 9'd0;
      if (k_byte == LAYOUT_COUNT_FIRST && pos_ff >= COUNT_FIRST_DS) begin
         start = COUNT_FIRST_DS;
      end else if (k_byte == LAYOUT_ADDR_COUNT_DATA && pos_ff >= ACD_DS) begin
         start = ACD_DS;
      end
   end

   // next frame state and result
   always_comb begin
      pos_in  = pos_ff;
      crc_in  = crc_ff;
      dev_in  = dev_ff;
      fc_in   = fc_ff;
      addr_in = addr_ff;
      cnt_in  = cnt_ff;
      bc_in   = bc_ff;
      tlo_in  = tlo_ff;
      thi_in  = thi_ff;
      exp_in  = exp_ff;
      res_valid = 1'b0;
      res       = '0;

      if (cmd == CMD_FRAME_END) begin
         res_valid           = 1'b1;
         res.result_kind     = KIND_REPORT;
         res.device_id       = dev_ff;
         res.function_code   = fc_ff;
         res.start_address   = addr_ff;
         res.register_count  = cnt_ff;
         res.data_byte_count = bc_ff;
         res.frame_status    = status;
         res.frame_length    = len;
         res.overlong        = over;
         pos_in  = 9'd0;
         crc_in  = cfg.crc_init;
         dev_in  = 8'd0;
         fc_in   = 8'd0;
         addr_in = 16'd0;
         cnt_in  = 16'd0;
         bc_in   = 8'd0;
         tlo_in  = 8'd0;
         thi_in  = 8'd0;
         exp_in  = 9'd0;
      end else begin
         if (in_frame) begin
            // crc over message bytes, trailer captured low byte first
            if (exp_ff == 9'd0 || pos_plus2 < {1'b0, exp_ff}) begin
               crc_in = crc_update(crc_ff, rx_byte);
            end else if (pos_plus2 == {1'b0, exp_ff}) begin
               tlo_in = rx_byte;
            end else begin
               thi_in = rx_byte;
            end

            // header bytes
            if (pos_ff == 9'd0) begin
               dev_in = rx_byte;
            end
            if (pos_ff == 9'd1) begin
               fc_in = rx_byte;
               if (k_byte == LAYOUT_FIXED) begin
                  exp_in = FIXED_LEN;
               end
            end

            // big-endian address and count
            if (k_byte == LAYOUT_FIXED || k_byte == LAYOUT_ADDR_COUNT_DATA) begin
               case (pos_ff)
                  9'd2:    addr_in = {rx_byte, addr_ff[7:0]};
                  9'd3:    addr_in = {addr_ff[15:8], rx_byte};
                  9'd4:    cnt_in  = {rx_byte, cnt_ff[7:0]};
                  9'd5:    cnt_in  = {cnt_ff[15:8], rx_byte};
                  default: addr_in = addr_ff;
               endcase
            end

            // byte count field or a data field byte
            if (k_byte == LAYOUT_COUNT_FIRST && pos_ff == 9'd2) begin
               bc_in  = rx_byte;
               exp_in = COUNT_FIRST_OH + {1'b0, rx_byte};
            end else if (k_byte == LAYOUT_ADDR_COUNT_DATA && pos_ff == 9'd6) begin
               bc_in  = rx_byte;
               exp_in = ACD_OH + {1'b0, rx_byte};
            end else if (start != 9'd0 && pos_ff < data_end) begin
               res_valid           = 1'b1;
               res.result_kind     = KIND_PAYLOAD;
               res.payload_value   = rx_byte;
               res.payload_index   = 8'(pos_ff - start);
               res.device_id       = dev_in;
               res.function_code   = fc_in;
               res.start_address   = addr_in;
               res.register_count  = cnt_in;
               res.data_byte_count = bc_in;
               res.frame_status    = STATUS_OK;
            end
         end
         if (pos_ff != POS_MAX) begin
            pos_in = pos_ff + 9'd1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pos_ff  <= 9'd0;
         crc_ff  <= CRC_INIT_RESET;
         dev_ff  <= 8'd0;
         fc_ff   <= 8'd0;
         addr_ff <= 16'd0;
         cnt_ff  <= 16'd0;
         bc_ff   <= 8'd0;
         tlo_ff  <= 8'd0;
         thi_ff  <= 8'd0;
         exp_ff  <= 9'd0;
      end else if (xfer) begin
         pos_ff  <= pos_in;
         crc_ff  <= crc_in;
         dev_ff  <= dev_in;
         fc_ff   <= fc_in;
         addr_ff <= addr_in;
         cnt_ff  <= cnt_in;
         bc_ff   <= bc_in;
         tlo_ff  <= tlo_in;
         thi_ff  <= thi_in;
         exp_ff  <= exp_in;
      end
   end

endmodule
`default_nettype wire

// ----- rtl/mrtu_out_reg.sv -----
// result register between the parser and the result channel
`default_nettype none
module mrtu_out_reg
   import mrtu_pkg::*;
(
   input  wire logic clock,
   input  wire logic reset,
   input  wire logic load,
   input  res_type   res_in,
   input  wire logic out_ready,
   output logic      out_valid,
   output logic      can_take,
   output res_type   res_out
);

   logic    valid_ff, valid_in;
   res_type data_ff,  data_in;

   // free when empty or when the held result leaves this cycle
   assign can_take = !valid_ff || out_ready;

   always_comb begin
      valid_in = valid_ff;
      data_in  = data_ff;
      if (load) begin
         valid_in = 1'b1;
         data_in  = res_in;
      end else if (out_ready) begin
         valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      data_ff <= data_in;
   end

   assign out_valid = valid_ff;
   assign res_out   = data_ff;

endmodule
`default_nettype wire

// ----- rtl/modbus_rtu_frame_checker_top.sv -----
// top level of the modbus rtu frame checker
//
// Checks Modbus RTU frames one transfer at a time: each input transfer is a
// received byte (req_tuser = 0) or a frame end mark for the silence timeout
// (req_tuser = 1). Data field bytes come out as payload results as they
// arrive; a frame end gives one status report (ok, too short, crc mismatch,
// unknown function or empty frame) and clears the frame state. One item is
// taken every clock cycle: the byte goes through the crc update and the
// field decode straight into the result register, so the only stall is a
// held result that the result side has not yet taken. Results appear in the
// cycle after the input transfer. The user must write registers through
// csr_we/csr_addr/csr_wdata only while no frame is in progress (not enforced).
`default_nettype none
module modbus_rtu_frame_checker_top
   import mrtu_pkg::*;
(
   input  wire logic        clock,
   input  wire logic        reset,
   // input channel
   input  wire logic        req_tvalid,
   output logic             req_tready,
   input  wire logic [7:0]  req_tdata,   // rx_byte
   input  wire logic        req_tuser,   // cmd
   // result channel
   output logic             rsp_tvalid,
   input  wire logic        rsp_tready,
   // payload_value, payload_index, device_id, function_code, start_address,
   // register_count, data_byte_count, frame_status, frame_length, overlong, pad
   output logic [87:0]      rsp_tdata,
   output logic             rsp_tuser,   // result_kind
   // configuration port
   input  wire logic        csr_we,
   input  wire logic [1:0]  csr_addr,
   input  wire logic [15:0] csr_wdata
);

   cfg_type cfg;
   res_type res;
   res_type res_q;
   logic    res_valid;
   logic    can_take;
   logic    xfer;

   assign req_tready = can_take;
   assign xfer       = req_tvalid && can_take;

   mrtu_cfg u_cfg (
      .clock     (clock),
      .reset     (reset),
      .csr_we    (csr_we),
      .csr_addr  (csr_addr),
      .csr_wdata (csr_wdata),
      .cfg       (cfg)
   );

   mrtu_parser u_parser (
      .clock     (clock),
      .reset     (reset),
      .cfg       (cfg),
      .xfer      (xfer),
      .cmd       (req_tuser),
      .rx_byte   (req_tdata),
      .res_valid (res_valid),
      .res       (res)
   );

   mrtu_out_reg u_out_reg (
      .clock     (clock),
      .reset     (reset),
      .load      (xfer && res_valid),
      .res_in    (res),
      .out_ready (rsp_tready),
      .out_valid (rsp_tvalid),
      .can_take  (can_take),
      .res_out   (res_q)
   );

   // result field packing, first field lowest
   assign rsp_tuser = res_q.result_kind;
   assign rsp_tdata = {4'b0000,
                       res_q.overlong,
                       res_q.frame_length,
                       res_q.frame_status,
                       res_q.data_byte_count,
                       res_q.register_count,
                       res_q.start_address,
                       res_q.function_code,
                       res_q.device_id,
                       res_q.payload_index,
                       res_q.payload_value};

endmodule
`default_nettype wire

// ----- test/tb.sv -----
// testbench for the modbus rtu frame checker: rtu frames against a frame-decode predictor
`timescale 1ns / 100ps

module tb;
   import mrtu_pkg::*;

   localparam int CYCLE_LIMIT  = 400000;
   localparam int HOLD_CYCLES  = 300;
   localparam int SWEEP_ITEMS  = 40;
   localparam int MAX_REPORTED = 10;

   logic        clock = 1'b0;
   logic        reset;
   logic        req_tvalid;
   logic        req_tready;
   logic [7:0]  req_tdata;
   logic        req_tuser;
   logic        rsp_tvalid;
   logic        rsp_tready;
   logic [87:0] rsp_tdata;
   logic        rsp_tuser;
   logic        csr_we;
   logic [1:0]  csr_addr;
   logic [15:0] csr_wdata;

   // predictor copy of the registers
   logic        cfg_role;
   logic [7:0]  cfg_rd_fc;
   logic [7:0]  cfg_wr_fc;
   logic [15:0] cfg_crc_init;

   // predictor copy of the frame state
   logic [8:0]  frm_pos;
   logic [15:0] frm_crc;
   logic [7:0]  hdr_dev;
   logic [7:0]  hdr_fc;
   logic [15:0] hdr_addr;
   logic [15:0] hdr_cnt;
   logic [7:0]  hdr_bc;
   logic [7:0]  trl_lo;
   logic [7:0]  trl_hi;
   logic [8:0]  exp_len;

   res_type     rtu_results_due[$];
   logic [7:0]  frame_buf[$];

   int          mismatches = 0;
   int          items_sent = 0;
   int          cycle_count = 0;
   int          results_seen = 0;
   bit          tx_steady = 1'b0;
   bit          rx_steady = 1'b0;
   bit          hold_req = 1'b0;
   int          hold_left = 0;

   modbus_rtu_frame_checker_top DUT (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .csr_we     (csr_we),
      .csr_addr   (csr_addr),
      .csr_wdata  (csr_wdata)
   );

   always #10 clock = ~clock;

   // reflected crc-16, one input bit at a time
   function automatic logic [15:0] crc16_byte(input logic [15:0] crc, input logic [7:0] b);
      logic [15:0] c;
      logic        mix;
      c = crc;
      for (int i = 0; i < 8; i++) begin
         mix = c[0] ^ b[i];
         c = c >> 1;
         if (mix) c = c ^ CRC_POLY;
      end
      return c;
   endfunction

   // layout picked by function code and role, read code wins a tie
   function automatic layout_type frame_layout(input logic [7:0] fc);
      if (fc == cfg_rd_fc) return cfg_role ? LAYOUT_FIXED : LAYOUT_COUNT_FIRST;
      if (fc == cfg_wr_fc) return cfg_role ? LAYOUT_ADDR_COUNT_DATA : LAYOUT_FIXED;
      return LAYOUT_NONE;
   endfunction

   function automatic res_type header_snapshot(input logic kind);
      res_type r;
      r = '0;
      r.result_kind     = kind;
      r.device_id       = hdr_dev;
      r.function_code   = hdr_fc;
      r.start_address   = hdr_addr;
      r.register_count  = hdr_cnt;
      r.data_byte_count = hdr_bc;
      return r;
   endfunction

   function automatic string format_result(input res_type r);
      return $sformatf({"kind %0d val %h idx %h dev %h fc %h addr %h cnt %h bc %h",
                        " st %0d len %0d ovl %0d"},
                       r.result_kind, r.payload_value, r.payload_index, r.device_id,
                       r.function_code, r.start_address, r.register_count,
                       r.data_byte_count, r.frame_status, r.frame_length, r.overlong);
   endfunction

   function automatic logic [7:0] body_byte(input int fill);
      return (fill < 0) ? 8'($urandom_range(0, 255)) : fill[7:0];
   endfunction

   task automatic clear_frame_state();
      frm_pos  = '0;
      frm_crc  = cfg_crc_init;
      hdr_dev  = '0;
      hdr_fc   = '0;
      hdr_addr = '0;
      hdr_cnt  = '0;
      hdr_bc   = '0;
      trl_lo   = '0;
      trl_hi   = '0;
      exp_len  = '0;
   endtask

   // frame decode of one accepted transfer, queues the result it causes
   task automatic decode_rtu_item(input logic cmd, input logic [7:0] b);
      res_type    r;
      layout_type k;
      status_type st;
      logic [8:0] len;
      int         p;
      int         el;
      int         start;
      p  = frm_pos;
      el = exp_len;
      if (cmd == CMD_FRAME_END) begin
         k   = frame_layout(hdr_fc);
         len = '0;
         if (p == 0) st = STATUS_UNKNOWN;
         else if (p == 1) st = STATUS_SHORT;
         else if (k == LAYOUT_NONE) st = STATUS_UNKNOWN;
         else if (el == 0 || p < el) st = STATUS_SHORT;
         else if ({trl_hi, trl_lo} != frm_crc) st = STATUS_CRC;
         else begin
            st  = STATUS_OK;
            len = exp_len;
         end
         r = header_snapshot(KIND_REPORT);
         r.frame_status = st;
         r.frame_length = len;
         r.overlong     = (el != 0 && p > el);
         rtu_results_due.push_back(r);
         clear_frame_state();
      end else begin
         if (el == 0 || p < el) begin
            // message bytes feed the crc, the last two are the trailer
            if (el == 0 || p + 2 < el) frm_crc = crc16_byte(frm_crc, b);
            else if (p + 2 == el) trl_lo = b;
            else trl_hi = b;
            if (p == 0) hdr_dev = b;
            if (p == 1) begin
               hdr_fc = b;
               if (frame_layout(b) == LAYOUT_FIXED) exp_len = FIXED_LEN;
            end
            k = frame_layout(hdr_fc);
            // big-endian address and count
            if (p >= 2 && (k == LAYOUT_FIXED || k == LAYOUT_ADDR_COUNT_DATA)) begin
               case (p)
                  2: hdr_addr[15:8] = b;
                  3: hdr_addr[7:0]  = b;
                  4: hdr_cnt[15:8]  = b;
                  5: hdr_cnt[7:0]   = b;
                  default: ;
               endcase
            end
            if (k == LAYOUT_COUNT_FIRST && p == 2) begin
               hdr_bc  = b;
               exp_len = COUNT_FIRST_OH + {1'b0, b};
            end else if (k == LAYOUT_ADDR_COUNT_DATA && p == 6) begin
               hdr_bc  = b;
               exp_len = ACD_OH + {1'b0, b};
            end else begin
               start = 0;
               if (k == LAYOUT_COUNT_FIRST && p >= 3) start = COUNT_FIRST_DS;
               else if (k == LAYOUT_ADDR_COUNT_DATA && p >= 7) start = ACD_DS;
               if (start != 0 && p < start + hdr_bc) begin
                  r = header_snapshot(KIND_PAYLOAD);
                  r.payload_value = b;
                  r.payload_index = 8'(p - start);
                  rtu_results_due.push_back(r);
               end
            end
         end
         if (frm_pos < POS_MAX) frm_pos = frm_pos + 9'd1;
      end
   endtask

   // one input transfer, with an occasional gap in front
   task automatic send_item(input logic cmd, input logic [7:0] b);
      if (!tx_steady && $urandom_range(0, 99) < 15) begin
         req_tvalid <= 1'b0;
         repeat ($urandom_range(1, 4)) @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tuser  <= cmd;
      req_tdata  <= b;
      do @(posedge clock); while (!req_tready);
      items_sent++;
      decode_rtu_item(cmd, b);
   endtask

   // drain all results, then give the last byte time to settle
   task automatic wait_idle();
      req_tvalid <= 1'b0;
      while (rtu_results_due.size() != 0) @(posedge clock);
      repeat (4) @(posedge clock);
   endtask

   // writes all four registers back to back, junk in unused upper bits
   task automatic set_config(input logic role, input logic [7:0] rd_fc,
                             input logic [7:0] wr_fc, input logic [15:0] crc_init);
      logic [15:0] val[4];
      val[REG_PARSE_ROLE] = {15'($urandom), role};
      val[REG_READ_FC]    = {8'($urandom), rd_fc};
      val[REG_WRITE_FC]   = {8'($urandom), wr_fc};
      val[REG_CRC_INIT]   = crc_init;
      wait_idle();
      for (int i = 0; i < 4; i++) begin
         csr_we    <= 1'b1;
         csr_addr  <= 2'(i);
         csr_wdata <= val[i];
         @(posedge clock);
      end
      csr_we       <= 1'b0;
      cfg_role     = role;
      cfg_rd_fc    = rd_fc;
      cfg_wr_fc    = wr_fc;
      cfg_crc_init = crc_init;
   endtask

   // well-formed frame for the current layout, crc from the frame's start value
   task automatic build_frame(input logic [7:0] dev, input logic [7:0] fc,
                              input int nbytes, input int fill);
      layout_type  k;
      logic [15:0] c;
      frame_buf.delete();
      frame_buf.push_back(dev);
      frame_buf.push_back(fc);
      k = frame_layout(fc);
      if (k == LAYOUT_FIXED || k == LAYOUT_ADDR_COUNT_DATA)
         repeat (4) frame_buf.push_back(body_byte(fill));
      if (k == LAYOUT_COUNT_FIRST || k == LAYOUT_ADDR_COUNT_DATA)
         frame_buf.push_back(8'(nbytes));
      if (k != LAYOUT_FIXED)
         repeat (nbytes) frame_buf.push_back(body_byte(fill));
      c = frm_crc;
      foreach (frame_buf[i]) c = crc16_byte(c, frame_buf[i]);
      frame_buf.push_back(c[7:0]);
      frame_buf.push_back(c[15:8]);
   endtask

   task automatic send_frame_buf();
      foreach (frame_buf[i]) send_item(CMD_BYTE, frame_buf[i]);
      send_item(CMD_FRAME_END, 8'($urandom_range(0, 255)));
   endtask

   task automatic add_extra_bytes(input int n);
      repeat (n) frame_buf.push_back(8'($urandom_range(0, 255)));
   endtask

   // mostly valid frames with random content, some broken, some noise
   task automatic send_random_frame();
      int         r;
      int         m;
      int         nb;
      logic [7:0] dev;
      logic [7:0] fc;
      r   = $urandom_range(0, 99);
      dev = ($urandom_range(0, 9) == 0) ? {8{1'($urandom)}} : 8'($urandom);
      if (r < 72) begin
         m = $urandom_range(0, 99);
         if (m < 45) fc = cfg_rd_fc;
         else if (m < 90) fc = cfg_wr_fc;
         else fc = 8'($urandom);
         nb = ($urandom_range(0, 99) < 4) ? $urandom_range(9, 255) : $urandom_range(0, 8);
         build_frame(dev, fc, nb, -1);
         m = $urandom_range(0, 99);
         if (m < 10 && frame_buf.size() > 2)
            frame_buf[$urandom_range(2, frame_buf.size() - 1)] ^= 8'($urandom_range(1, 255));
         else if (m < 20)
            repeat ($urandom_range(1, frame_buf.size() - 1)) void'(frame_buf.pop_back());
         else if (m < 28)
            add_extra_bytes($urandom_range(1, 5));
      end else if (r < 80) begin
         frame_buf.delete();
      end else begin
         frame_buf.delete();
         add_extra_bytes($urandom_range(0, 10));
      end
      send_frame_buf();
   endtask

   // empty, short, unknown, crc error, overlong and field extremes at reset settings
   task automatic test_corner_cases();
      frame_buf.delete();
      send_frame_buf();
      frame_buf.push_back(8'h00);
      send_frame_buf();
      frame_buf.delete();
      frame_buf.push_back(8'hFF);
      frame_buf.push_back(8'h55);
      frame_buf.push_back(8'h00);
      send_frame_buf();
      // read frame cut before its byte count
      frame_buf.delete();
      frame_buf.push_back(8'h11);
      frame_buf.push_back(cfg_rd_fc);
      send_frame_buf();
      build_frame(8'hFF, cfg_rd_fc, 2, 8'hFF);
      send_frame_buf();
      build_frame(8'h00, cfg_wr_fc, 0, 8'h00);
      send_frame_buf();
      build_frame(8'hFF, cfg_wr_fc, 0, 8'hFF);
      send_frame_buf();
      // bad trailer
      build_frame(8'h01, cfg_rd_fc, 1, -1);
      frame_buf[frame_buf.size() - 1] ^= 8'h5A;
      send_frame_buf();
      build_frame(8'h02, cfg_wr_fc, 0, -1);
      add_extra_bytes(2);
      send_frame_buf();
      build_frame(8'h03, cfg_wr_fc, 0, -1);
      repeat (4) void'(frame_buf.pop_back());
      send_frame_buf();
   endtask

   // no gaps on either side
   task automatic test_full_rate();
      int start;
      tx_steady = 1'b1;
      rx_steady = 1'b1;
      start = items_sent;
      while (items_sent - start < 150) send_random_frame();
      wait_idle();
      tx_steady = 1'b0;
      rx_steady = 1'b0;
   endtask

   // receiver holds off while a long data frame keeps coming
   task automatic test_backpressure();
      hold_req = 1'b1;
      build_frame(8'h21, cfg_rd_fc, 60, -1);
      send_frame_buf();
      wait_idle();
   endtask

   // largest data field with enough extra bytes to saturate the position
   task automatic test_long_frame();
      build_frame(8'h34, cfg_rd_fc, 255, -1);
      add_extra_bytes(300);
      send_frame_buf();
      wait_idle();
   endtask

   // random frames over several register settings, extremes included
   task automatic test_config_sweep();
      int         start;
      logic [7:0] fc;
      for (int ph = 0; ph < 10; ph++) begin
         fc = 8'($urandom);
         case (ph)
            0: set_config(1'b0, READ_FC_RESET, WRITE_FC_RESET, CRC_INIT_RESET);
            1: set_config(1'b1, READ_FC_RESET, WRITE_FC_RESET, CRC_INIT_RESET);
            2: set_config(1'b1, 8'h00, 8'hFF, 16'h0000);
            3: set_config(1'b0, 8'hFF, 8'h00, 16'h0000);
            4: set_config(1'b1, fc, fc, 16'($urandom));
            5: set_config(1'b0, fc, fc, 16'($urandom));
            default: set_config(1'($urandom), 8'($urandom), 8'($urandom), 16'($urandom));
         endcase
         start = items_sent;
         while (items_sent - start < SWEEP_ITEMS) send_random_frame();
      end
      wait_idle();
   endtask

   // result side: random stalls, or a long hold when asked
   initial begin
      rsp_tready <= 1'b0;
      forever begin
         @(posedge clock);
         if (hold_left > 0) begin
            hold_left--;
            rsp_tready <= 1'b0;
         end else if (hold_req) begin
            hold_req  = 1'b0;
            hold_left = HOLD_CYCLES;
            rsp_tready <= 1'b0;
         end else if (rx_steady) begin
            rsp_tready <= 1'b1;
         end else begin
            rsp_tready <= ($urandom_range(0, 99) >= 15);
         end
      end
   end

   // compare each result transfer with the oldest queued one
   always @(posedge clock) begin : check_results
      res_type got;
      res_type want;
      if (!reset && rsp_tvalid && rsp_tready) begin
         got.result_kind     = rsp_tuser;
         got.payload_value   = rsp_tdata[7:0];
         got.payload_index   = rsp_tdata[15:8];
         got.device_id       = rsp_tdata[23:16];
         got.function_code   = rsp_tdata[31:24];
         got.start_address   = rsp_tdata[47:32];
         got.register_count  = rsp_tdata[63:48];
         got.data_byte_count = rsp_tdata[71:64];
         got.frame_status    = status_type'(rsp_tdata[73:72]);
         got.frame_length    = rsp_tdata[82:74];
         got.overlong        = rsp_tdata[83];
         results_seen++;
         if (rtu_results_due.size() == 0) begin
            mismatches++;
            if (mismatches <= MAX_REPORTED)
               $display("result %0d with nothing queued: %s", results_seen, format_result(got));
         end else begin
            want = rtu_results_due.pop_front();
            if (got.result_kind !== want.result_kind ||
                got.payload_value !== want.payload_value ||
                got.payload_index !== want.payload_index ||
                got.device_id !== want.device_id ||
                got.function_code !== want.function_code ||
                got.start_address !== want.start_address ||
                got.register_count !== want.register_count ||
                got.data_byte_count !== want.data_byte_count ||
                got.frame_status !== want.frame_status ||
                got.frame_length !== want.frame_length ||
                got.overlong !== want.overlong) begin
               mismatches++;
               if (mismatches <= MAX_REPORTED) begin
                  $display("result %0d expected: %s", results_seen, format_result(want));
                  $display("result %0d actual:   %s", results_seen, format_result(got));
               end
            end
         end
      end
   end

   // run limit
   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("modbus_rtu_frame_checker_top: mismatch");
         $finish;
      end
   end

   initial begin
      reset      <= 1'b1;
      req_tvalid <= 1'b0;
      req_tdata  <= '0;
      req_tuser  <= CMD_BYTE;
      csr_we     <= 1'b0;
      csr_addr   <= REG_PARSE_ROLE;
      csr_wdata  <= '0;
      cfg_role     = ROLE_RESET;
      cfg_rd_fc    = READ_FC_RESET;
      cfg_wr_fc    = WRITE_FC_RESET;
      cfg_crc_init = CRC_INIT_RESET;
      clear_frame_state();
      repeat (7) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      test_corner_cases();
      test_full_rate();
      test_backpressure();
      test_long_frame();
      test_config_sweep();

      wait_idle();
      repeat (8) @(posedge clock);
      if (mismatches == 0) begin
         $display("modbus_rtu_frame_checker_top: match");
      end else begin
         $display("modbus_rtu_frame_checker_top: mismatch");
      end
      $finish;
   end

endmodule
